[sv/swa_pkg.sv]
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants for the sliding window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int unsigned RingDepth = 64;
  localparam int unsigned SlotW     = $clog2(RingDepth);
  localparam int unsigned FillW     = $clog2(RingDepth + 1);
  localparam int unsigned QOne      = 65536;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgTimeMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecayMode  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindowSpan = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDecayRatio = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_WRITE,
    ST_ACC_RD,
    ST_ACC_WAIT,
    ST_WEIGHT,
    ST_ACC_ADD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        time_mode;
    logic        weighted;
    logic [31:0] window_span;
    logic [16:0] decay_ratio;
  } cfg_t;

  typedef struct packed {
    logic [31:0] result_time;
    logic [31:0] window_average;
    logic [6:0]  samples_used;
    logic        overflow_drop;
  } result_t;

endpackage

`default_nettype wire

[sv/sliding_window_average_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_average_top
// Sliding window mean or decayed mean over a ring of timestamped samples.
// ----------------------------------------------------------------------------
// One sample is handled at a time. Time mode first walks the oldest ring
// entries (ST_EVICT_RD, ST_EVICT_CHK) to drop expired samples, then the
// window is walked newest first through ST_ACC_RD, ST_ACC_WAIT and
// ST_ACC_ADD per sample, with ST_WEIGHT between the last two when decay is
// on (the weight unit takes one age bit a cycle). A serial divide finishes
// each result. The output register frees the input as soon as the result
// is latched.
`default_nettype none

module sliding_window_average_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [31:0] sample_time, [63:32] sample_value
  input  wire logic [63:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_time, [63:32] window_average, [70:64] samples_used,
  // [71] overflow_drop
  output      logic [71:0] m_axis_tdata
);

  localparam int unsigned SW = swa_pkg::SlotW;
  localparam int unsigned FW = swa_pkg::FillW;

  swa_pkg::cfg_t    cfg_q;
  swa_pkg::state_e  state_q, state_d;
  swa_pkg::result_t res_q;
  logic             res_valid_q;

  logic [SW-1:0] wslot_q, wslot_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] used_q, used_d, k_q, k_d;
  logic [31:0]   tnow_q, tnow_d;
  logic [31:0]   vin_q, vin_d;
  logic          drop_q, drop_d;
  logic signed [63:0] num_q, num_d, den_q, den_d;
  logic signed [37:0] sum_q, sum_d;
  logic signed [31:0] sval_q, sval_d;

  logic          mem_we;
  logic [SW-1:0] raddr;
  logic [63:0]   rdata;
  logic          w_start, w_done;
  logic [16:0]   weight;
  logic [31:0]   age;
  logic [16:0]   ratio;
  logic          d_start, d_done;
  logic signed [63:0] quot;
  logic [FW-1:0] kk;
  logic [32:0]   tsum;
  logic          accept, out_free;
  logic signed [49:0] prod;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !res_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == swa_pkg::ST_IDLE);
  assign ratio = (cfg_q.decay_ratio > 17'(swa_pkg::QOne)) ? 17'(swa_pkg::QOne)
                                                          : cfg_q.decay_ratio;
  assign kk = (cfg_q.window_span == '0) ? FW'(1) :
              (cfg_q.window_span > 32'(swa_pkg::RingDepth)) ? FW'(swa_pkg::RingDepth)
                                                            : cfg_q.window_span[FW-1:0];
  assign tsum = {1'b0, rdata[31:0]} + {1'b0, cfg_q.window_span};
  assign age  = cfg_q.time_mode ? ((rdata[31:0] > tnow_q) ? 32'd0 : tnow_q - rdata[31:0])
                                : 32'(k_q);
  assign prod = $signed({1'b0, weight}) * sval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{time_mode: 1'b0, weighted: 1'b0, window_span: 32'd4,
                 decay_ratio: 17'(swa_pkg::QOne)};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swa_pkg::CfgTimeMode:   cfg_q.time_mode   <= cfg_data_i[0];
        swa_pkg::CfgDecayMode:  cfg_q.weighted    <= cfg_data_i[0];
        swa_pkg::CfgWindowSpan: cfg_q.window_span <= cfg_data_i;
        swa_pkg::CfgDecayRatio: cfg_q.decay_ratio <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    wslot_d = wslot_q;
    fill_d  = fill_q;
    used_d  = used_q;
    k_d     = k_q;
    tnow_d  = tnow_q;
    vin_d   = vin_q;
    drop_d  = drop_q;
    num_d   = num_q;
    den_d   = den_q;
    sum_d   = sum_q;
    sval_d  = sval_q;
    mem_we  = 1'b0;
    raddr   = wslot_q - SW'(k_q) - SW'(1);
    w_start = 1'b0;
    d_start = 1'b0;
    unique case (state_q)
      swa_pkg::ST_IDLE: begin
        if (accept) begin
          tnow_d  = s_axis_tdata[31:0];
          vin_d   = s_axis_tdata[63:32];
          drop_d  = 1'b0;
          state_d = cfg_q.time_mode ? swa_pkg::ST_EVICT_RD : swa_pkg::ST_WRITE;
        end
      end
      swa_pkg::ST_EVICT_RD: begin
        raddr = wslot_q - SW'(fill_q);
        if (fill_q == '0) begin
          state_d = swa_pkg::ST_WRITE;
        end else begin
          state_d = swa_pkg::ST_EVICT_CHK;
        end
      end
      swa_pkg::ST_EVICT_CHK: begin
        if (tsum < {1'b0, tnow_q}) begin
          fill_d  = fill_q - FW'(1);
          state_d = swa_pkg::ST_EVICT_RD;
        end else begin
          state_d = swa_pkg::ST_WRITE;
        end
      end
      swa_pkg::ST_WRITE: begin
        mem_we  = 1'b1;
        wslot_d = wslot_q + SW'(1);
        if (fill_q >= FW'(swa_pkg::RingDepth)) begin
          if (cfg_q.time_mode) drop_d = 1'b1;
        end else begin
          fill_d = fill_q + FW'(1);
        end
        k_d   = '0;
        num_d = '0;
        den_d = '0;
        sum_d = '0;
        if (cfg_q.time_mode) begin
          used_d  = (fill_q >= FW'(swa_pkg::RingDepth)) ? fill_q : fill_q + FW'(1);
          state_d = swa_pkg::ST_ACC_RD;
        end else begin
          used_d  = kk;
          state_d = ((fill_q >= FW'(swa_pkg::RingDepth) ? fill_q : fill_q + FW'(1)) < kk)
                    ? swa_pkg::ST_IDLE : swa_pkg::ST_ACC_RD;
        end
      end
      swa_pkg::ST_ACC_RD: begin
        state_d = swa_pkg::ST_ACC_WAIT;
      end
      swa_pkg::ST_ACC_WAIT: begin
        sval_d  = rdata[63:32];
        sum_d   = sum_q + 38'($signed(rdata[63:32]));
        if (cfg_q.weighted) begin
          state_d = swa_pkg::ST_WEIGHT;
        end else begin
          state_d = swa_pkg::ST_ACC_ADD;
        end
      end
      swa_pkg::ST_WEIGHT: begin
        if (w_done) begin
          num_d   = num_q + 64'(prod);
          den_d   = den_q + 64'(weight);
          state_d = swa_pkg::ST_ACC_ADD;
        end
      end
      swa_pkg::ST_ACC_ADD: begin
        k_d = k_q + FW'(1);
        if (k_q + FW'(1) == used_q) begin
          if (!cfg_q.weighted) begin
            num_d = 64'(sum_q);
            den_d = 64'(used_q);
          end
          d_start = 1'b1;
          state_d = swa_pkg::ST_DIV;
        end else begin
          state_d = swa_pkg::ST_ACC_RD;
        end
      end
      swa_pkg::ST_DIV: begin
        if (d_done) state_d = swa_pkg::ST_OUT;
      end
      swa_pkg::ST_OUT: begin
        if (out_free) state_d = swa_pkg::ST_IDLE;
      end
      default: state_d = swa_pkg::ST_IDLE;
    endcase
    if (state_q == swa_pkg::ST_ACC_WAIT && cfg_q.weighted) w_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swa_pkg::ST_IDLE;
      wslot_q     <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wslot_q <= wslot_d;
      fill_q  <= fill_d;
      if (state_q == swa_pkg::ST_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    used_q  <= used_d;
    k_q     <= k_d;
    tnow_q  <= tnow_d;
    vin_q   <= vin_d;
    drop_q  <= drop_d;
    num_q   <= num_d;
    den_q   <= den_d;
    sum_q   <= sum_d;
    sval_q  <= sval_d;
    if (state_q == swa_pkg::ST_OUT && out_free) begin
      res_q.result_time    <= tnow_q;
      res_q.window_average <= quot[31:0];
      res_q.samples_used   <= 7'(used_q);
      res_q.overflow_drop  <= drop_q;
    end
  end

  swa_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wslot_q),
    .wdata_i ({vin_q, tnow_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  swa_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (w_start),
    .age_i    (age),
    .ratio_i  (ratio),
    .done_o   (w_done),
    .weight_o (weight)
  );

  swa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d_start),
    .num_i   (num_d),
    .den_i   (den_d),
    .done_o  (d_done),
    .quot_o  (quot)
  );

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {res_q.overflow_drop, res_q.samples_used,
                          res_q.window_average, res_q.result_time};

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(swa_pkg::RingDepth)) else $error("fill level above ring depth");
  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[70:64] != 7'd0) else $error("empty window emitted");
  a_drop_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[71]) |-> cfg_q.time_mode)
    else $error("drop flagged in count mode");
`endif

endmodule

`default_nettype wire

[sv/swa_ring_mem.sv]
// ----------------------------------------------------------------------------
// swa_ring_mem
// Sample ring: one write port and one registered read port, time and value.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ring_mem (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [swa_pkg::SlotW-1:0] waddr_i,
  input  wire logic [63:0]              wdata_i,
  input  wire logic [swa_pkg::SlotW-1:0] raddr_i,
  output      logic [63:0]              rdata_o
);

  logic [63:0] mem_q [swa_pkg::RingDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/swa_divider.sv]
// ----------------------------------------------------------------------------
// swa_divider
// Signed 64 by 64 bit divider, one quotient bit a cycle, truncates to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [63:0] den_i,
  output      logic               done_o,
  output      logic signed [63:0] quot_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i[63] ? 64'(-num_i) : num_i;
      den_d  = den_i[63] ? 64'(-den_i) : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[63]} - {1'b0, den_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'(-quo_q) : quo_q;

endmodule

`default_nettype wire

[sv/swa_weight.sv]
// ----------------------------------------------------------------------------
// swa_weight
// Weight ratio^age by square and multiply, one age bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_weight (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] age_i,
  input  wire logic [16:0] ratio_i,
  output      logic        done_o,
  output      logic [16:0] weight_o
);

  logic [31:0] age_q, age_d;
  logic [16:0] w_q, w_d, b_q, b_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] wp, bp;

  always_comb begin
    age_d  = age_q;
    w_d    = w_q;
    b_d    = b_q;
    busy_d = busy_q;
    done_d = 1'b0;
    wp     = w_q * b_q;
    bp     = b_q * b_q;
    if (start_i) begin
      age_d  = age_i;
      w_d    = 17'(swa_pkg::QOne);
      b_d    = ratio_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (age_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (age_q[0]) begin
          w_d = wp[32:16];
        end
        b_d   = bp[32:16];
        age_d = age_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
    w_q   <= w_d;
    b_q   <= b_d;
  end

  assign done_o   = done_q;
  assign weight_o = w_q;

endmodule

`default_nettype wire

[sim/sliding_window_average_top_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_average_top_test
// Self-checking testbench for the sliding window averager.
// ----------------------------------------------------------------------------
// A directed table, then random samples, go through count and time windows
// with plain and decayed means. Each sample's outcome is predicted in the
// bench and compared with the output stream, while the handshake throttles
// both sides of the block.
`timescale 1ns / 1ps

module sliding_window_average_top_test;

  localparam int MaxCycles = 20000000;
  localparam int DrainCycles = 300;
  localparam int TableRows = 9;

  typedef struct {
    logic [31:0] stamp;
    logic [31:0] reading;
    logic        has_avg;
    logic [71:0] avg_word;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  sliding_window_average_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic        mode_time, mode_decay;
  logic [31:0] span;
  logic [16:0] ratio;
  logic signed [31:0] vals [swa_pkg::RingDepth];
  logic [31:0] stamps [swa_pkg::RingDepth];
  int unsigned wr_slot, fill;

  logic [71:0] avg_queue [$];
  int          errors = 0;
  int          results_seen = 0;
  int          send_idle = 0, recv_idle = 0;
  bit          recv_hold = 1'b0;
  longint      cycles = 0;
  logic [31:0] now_t = 0;

  task automatic report(input string what, input logic [71:0] got, input logic [71:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] age_weight(input logic [63:0] age, input logic [16:0] r);
    logic [63:0] w, b;
    w = 64'd65536;
    b = {47'd0, r};
    while (age != 0) begin
      if (age[0]) w = (w * b) >> 16;
      b = (b * b) >> 16;
      age = age >> 1;
    end
    return w[31:0];
  endfunction

  // Returns 1 and the packed result when the sample produces an average.
  function automatic bit predict_average(input logic [31:0] t, input logic [31:0] raw,
                                         output logic [71:0] word);
    int unsigned used, kk, s, k;
    logic dropped;
    logic [16:0] r;
    logic signed [63:0] num, den, total, avg;
    logic [63:0] age;
    logic [31:0] w;
    dropped = 1'b0;
    num = 0; den = 0; total = 0;
    word = '0;
    r = (ratio > swa_pkg::QOne) ? 17'(swa_pkg::QOne) : ratio;
    if (mode_time) begin
      while (fill > 0) begin
        s = (wr_slot + swa_pkg::RingDepth - fill) % swa_pkg::RingDepth;
        if ({32'd0, stamps[s]} + {32'd0, span} < {32'd0, t}) fill--;
        else break;
      end
      if (fill >= swa_pkg::RingDepth) begin
        fill = swa_pkg::RingDepth - 1;
        dropped = 1'b1;
      end
    end
    vals[wr_slot] = raw;
    stamps[wr_slot] = t;
    wr_slot = (wr_slot + 1) % swa_pkg::RingDepth;
    if (fill < swa_pkg::RingDepth) fill++;
    if (mode_time) used = fill;
    else begin
      kk = (span == 0) ? 1 : (span > swa_pkg::RingDepth) ? swa_pkg::RingDepth : span;
      if (fill < kk) return 0;
      used = kk;
    end
    for (k = 0; k < used; k++) begin
      s = (wr_slot + swa_pkg::RingDepth - 1 - k) % swa_pkg::RingDepth;
      total += vals[s];
      if (mode_decay) begin
        if (mode_time) age = (stamps[s] > t) ? 0 : {32'd0, t - stamps[s]};
        else age = k;
        w = age_weight(age, r);
        num += $signed({32'd0, w}) * vals[s];
        den += $signed({32'd0, w});
      end
    end
    avg = mode_decay ? num / den : total / $signed(64'(used));
    word = {dropped, 7'(used), avg[31:0], t};
    return 1;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      swa_pkg::CfgTimeMode:   mode_time = data[0];
      swa_pkg::CfgDecayMode:  mode_decay = data[0];
      swa_pkg::CfgWindowSpan: span = data;
      swa_pkg::CfgDecayRatio: ratio = data[16:0];
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (avg_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic tm, input logic dm, input logic [31:0] sp,
                           input logic [16:0] ra);
    wait_idle();
    write_reg(swa_pkg::CfgTimeMode, {31'd0, tm});
    write_reg(swa_pkg::CfgDecayMode, {31'd0, dm});
    write_reg(swa_pkg::CfgWindowSpan, sp);
    write_reg(swa_pkg::CfgDecayRatio, {15'd0, ra});
  endtask

  task automatic send_sample(input logic [31:0] t, input logic [31:0] v,
                             input bit has_typed, input logic [71:0] typed);
    logic [71:0] word;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_average(t, v, word)) begin
      if (has_typed && typed != word) report("table row", typed, word);
      avg_queue.insert(avg_queue.size(), word);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("timeout");
      $display("TEST FAILED");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (avg_queue.size() == 0) report("unexpected result", m_axis_tdata, '0);
      else begin
        if (m_axis_tdata[31:0] != avg_queue[0][31:0])
          report("result_time", m_axis_tdata, avg_queue[0]);
        if (m_axis_tdata[63:32] != avg_queue[0][63:32])
          report("window_average", m_axis_tdata, avg_queue[0]);
        if (m_axis_tdata[70:64] != avg_queue[0][70:64])
          report("samples_used", m_axis_tdata, avg_queue[0]);
        if (m_axis_tdata[71] != avg_queue[0][71])
          report("overflow_drop", m_axis_tdata, avg_queue[0]);
        avg_queue.delete(0);
      end
    end
    m_axis_tready <= !recv_hold && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  task automatic random_phase(input int count, input bit well_ordered);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      if (well_ordered || $urandom_range(3) != 0) now_t += $urandom_range(3);
      else now_t += $urandom_range(60);
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        default: v = $urandom_range(20'hfffff) - 32'h80000;
      endcase
      send_sample(now_t, v, 0, '0);
    end
  endtask

  vec_t table_rows [TableRows];

  initial begin
    mode_time = 0; mode_decay = 0; span = 4; ratio = 17'(swa_pkg::QOne);
    wr_slot = 0; fill = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // after reset: count window of four, plain mean
    table_rows[0] = '{32'd0, 32'h7fff_ffff, 1'b0, '0};
    table_rows[1] = '{32'd0, 32'h7fff_ffff, 1'b0, '0};
    table_rows[2] = '{32'd1, 32'h7fff_ffff, 1'b0, '0};
    table_rows[3] = '{32'd1, 32'h7fff_ffff, 1'b1, {1'b0, 7'd4, 32'h7fff_ffff, 32'd1}};
    table_rows[4] = '{32'd2, 32'h8000_0000, 1'b0, '0};
    table_rows[5] = '{32'd2, 32'h8000_0000, 1'b0, '0};
    table_rows[6] = '{32'd3, 32'h8000_0000, 1'b0, '0};
    table_rows[7] = '{32'd3, 32'h8000_0000, 1'b1, {1'b0, 7'd4, 32'h8000_0000, 32'd3}};
    table_rows[8] = '{32'd4, 32'h0001_0000, 1'b0, '0};
    foreach (table_rows[i])
      send_sample(table_rows[i].stamp, table_rows[i].reading, table_rows[i].has_avg,
                  table_rows[i].avg_word);
    now_t = 4;
    // K of zero saturates to one; K above the ring saturates to the depth
    configure(0, 0, 32'd0, 17'(swa_pkg::QOne));
    send_sample(32'd5, 32'h0002_0000, 1, {1'b0, 7'd1, 32'h0002_0000, 32'd5});
    configure(0, 1, 32'hffff_ffff, 17'h1ffff);
    send_sample(32'd6, 32'hffff_0000, 0, '0);
    configure(1, 1, 32'd3, 17'd0);
    send_sample(32'd7, 32'h1234_5678, 0, '0);
    send_sample(32'd20, 32'h8765_4321, 1, {1'b0, 7'd1, 32'h8765_4321, 32'd20});
    configure(1, 0, 32'hffff_ffff, 17'd32768);
    send_sample(32'hffff_fffe, 32'd5, 0, '0);
    send_sample(32'hffff_ffff, 32'hffff_fffb, 0, '0);
    now_t = 0;
    configure(1, 0, 32'd0, 17'(swa_pkg::QOne));
    send_sample(32'd0, 32'd0, 0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 33 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 33 : 0;
      for (int c = 0; c < 6; c++) begin
        case (c)
          0: configure(0, 0, $urandom_range(1, 8), 17'($urandom_range(65536)));
          1: configure(0, 1, $urandom_range(1) ? 32'd64 : $urandom_range(1, 70),
                       $urandom_range(1) ? 17'($urandom_range(65536)) : 17'd65000);
          2: configure(1, 0, $urandom_range(1) ? 32'hffff_ffff : $urandom_range(0, 40),
                       17'd65536);
          3: configure(1, 1, $urandom_range(0, 30), 17'($urandom_range(131071)));
          4: configure(0, 1, $urandom, 17'd0);
          default: configure(1, 1, 32'hffff_ffff, 17'd65536);
        endcase
        random_phase(75, c != 3);
        if (c == 2) begin
          // sender pause until the output side has caught up
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (avg_queue.size() != 0) @(posedge clk_i);
        end
      end
    end
    // long receiver hold while the sender keeps pushing
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      random_phase(10, 1);
    join
    wait_idle();
    $display("covered count and time windows, plain and decayed means, %0d results",
             results_seen);
    $display("with saturated spans and ratios, overflow drops and throttled handshakes");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
